### design/ssnpp_pkg.sv
// shared types and constants for the screen-space nearest point pick core
// depends on nothing; used by every module of the block

package ssnpp_pkg;

	localparam int unsigned IDX_W = 3;

	typedef enum logic [IDX_W-1:0] {
		REG_WIDTH  = 3'd0,
		REG_HEIGHT = 3'd1,
		REG_CUR_X  = 3'd2,
		REG_CUR_Y  = 3'd3,
		REG_RADIUS = 3'd4
	} reg_idx_t;

	localparam int unsigned MODE_ROW = 0;
	localparam int unsigned MODE_OBJ = 1;

	localparam logic signed [31:0] PIX_SAT_HI = 32'sd131071;
	localparam logic signed [31:0] PIX_SAT_LO = -32'sd65536;

	// item handed from front to back through the queue
	typedef struct packed {
		logic        is_obj;
		logic [1:0]  row;
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
		logic [15:0] id;
		logic        last;
	} qitem_t;

	// viewport and cursor settings seen by the back end
	typedef struct packed {
		logic [12:0] width;
		logic [12:0] height;
		logic [15:0] cur_x;
		logic [15:0] cur_y;
	} view_cfg_t;

	// floor(v / 2^s) of a signed product, arithmetic shift is a floor
	function automatic logic signed [63:0] fshift(input logic signed [63:0] v,
			input int unsigned s);
		fshift = v >>> s;
	endfunction

endpackage

### design/screen_space_nearest_point_pick_core.sv
// top level of the screen-space nearest point pick core
// depends on ssnpp_pkg, ssnpp_front, ssnpp_back
//
// channel  | dir | handshake               | payload
// s_axis   | in  | s_axis_tvalid/tready    | tdata, tuser=mode, tlast=last
// m_axis   | out | m_axis_tvalid/tready    | tdata=picked_id, tuser=found
// cfg      | in  | cfg_valid/cfg_ready     | cfg_index, cfg_data
//
// the back end stores a row item on take; an object is taken, and with w <= 0 goes
// from the w row straight to output; a visible object projects three rows, runs two
// divides on the 82-bit bit-serial divider, then does the compare and the output
// reset clears the matrix, the running best and the queue; registers go to defaults
// a two-entry queue lets the input run ahead while the back end or the
// output is stalled; a result waits in the output register

module screen_space_nearest_point_pick_core #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// row_index [1:0], entry_a [33:2], entry_b [65:34], entry_c [97:66],
	// entry_d [129:98], pos_x [161:130], pos_y [193:162], pos_z [225:194],
	// object_id [241:226], zero fill to 248
	input  logic [247:0] s_axis_tdata,
	input  logic         s_axis_tuser,   // mode
	input  logic         s_axis_tlast,   // last
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [15:0]  m_axis_tdata,   // picked_id
	output logic         m_axis_tuser,   // found
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [15:0]  cfg_data
);

	ssnpp_pkg::qitem_t    in_item, q_item;
	ssnpp_pkg::view_cfg_t vcfg_q;
	logic                 q_valid, q_take, restart, cfg_wr;
	logic [15:0]          radius_q;
	logic [15:0]          sq_src;
	logic [31:0]          radius_sq;

	// an object carries pos_x/y/z in the entry a/b/c slots of the queue item
	assign in_item.is_obj = s_axis_tuser;
	assign in_item.row    = s_axis_tdata[1:0];
	assign in_item.a      = in_item.is_obj ? s_axis_tdata[161:130] : s_axis_tdata[33:2];
	assign in_item.b      = in_item.is_obj ? s_axis_tdata[193:162] : s_axis_tdata[65:34];
	assign in_item.c      = in_item.is_obj ? s_axis_tdata[225:194] : s_axis_tdata[97:66];
	assign in_item.d      = s_axis_tdata[129:98];
	assign in_item.id     = s_axis_tdata[241:226];
	assign in_item.last   = s_axis_tlast;

	// config registers
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign restart   = cfg_wr && (cfg_index == ssnpp_pkg::REG_RADIUS);
	// a radius write squares the new value, otherwise the stored radius
	assign sq_src    = restart ? cfg_data : radius_q;
	assign radius_sq = 32'(sq_src) * 32'(sq_src);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcfg_q.width  <= 13'd1024;
			vcfg_q.height <= 13'd1024;
			vcfg_q.cur_x  <= '0;
			vcfg_q.cur_y  <= '0;
			radius_q      <= 16'd480;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				ssnpp_pkg::REG_WIDTH:  vcfg_q.width  <= cfg_data[12:0];
				ssnpp_pkg::REG_HEIGHT: vcfg_q.height <= cfg_data[12:0];
				ssnpp_pkg::REG_CUR_X:  vcfg_q.cur_x  <= cfg_data;
				ssnpp_pkg::REG_CUR_Y:  vcfg_q.cur_y  <= cfg_data;
				ssnpp_pkg::REG_RADIUS: radius_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	ssnpp_front #(.DEPTH_LOG2(1)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_item  (in_item),
		.q_valid  (q_valid),
		.q_take   (q_take),
		.q_item   (q_item)
	);

	ssnpp_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_take    (q_take),
		.q_item    (q_item),
		.vcfg      (vcfg_q),
		.restart   (restart),
		.radius_sq (radius_sq),
		.res_valid (m_axis_tvalid),
		.res_ready (m_axis_tready),
		.res_found (m_axis_tuser),
		.res_id    (m_axis_tdata)
	);

	// a result that is not found carries id zero
	a_id_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
		else $error("not-found result with nonzero id");

	// stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("result dropped while stalled");

	// a radius write lands in the radius register
	a_radius_kept: assert property (@(posedge clk) disable iff (!arst_n)
		restart |=> (radius_q == $past(cfg_data)))
		else $error("radius write lost");

endmodule

### design/ssnpp_front.sv
// front end: accepts items, keeps them in a short queue for the back end
// depends on ssnpp_pkg

module ssnpp_front #(
	parameter int unsigned DEPTH_LOG2 = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  ssnpp_pkg::qitem_t in_item,
	output logic              q_valid,
	input  logic              q_take,
	output ssnpp_pkg::qitem_t q_item
);

	localparam int unsigned DEPTH = 1 << DEPTH_LOG2;

	ssnpp_pkg::qitem_t          mem_q [DEPTH];
	logic [DEPTH_LOG2-1:0]      wp_q, rp_q;
	logic [DEPTH_LOG2:0]        cnt_q;
	logic                       push, pop;

	assign in_ready = (cnt_q != DEPTH_LOG2'(0) + (DEPTH_LOG2+1)'(DEPTH));
	assign q_valid  = (cnt_q != '0);
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_take;
	assign q_item   = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop)  rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (DEPTH_LOG2+1)'(push) - (DEPTH_LOG2+1)'(pop);
		end
	end

endmodule

### design/ssnpp_pixdiv.sv
// bit-serial floor divider producing a saturated pixel coordinate
// depends on ssnpp_pkg

module ssnpp_pixdiv (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [63:0] num,
	input  logic        [63:0] den,
	input  logic        [12:0] pixels,
	output logic               done,
	output logic signed [31:0] pix
);

	// computes floor(num * pixels*16 / den), den > 0, by restoring division of a
	// 82-bit magnitude product, one quotient bit per cycle
	localparam int unsigned NW = 82;

	logic [NW-1:0]  rem_q, dvd_q;
	logic [63:0]    den_q;
	logic [NW-1:0]  quo_q;
	logic           neg_q, busy_q, zs_q;
	logic [6:0]     cnt_q;
	logic [NW:0]    trial;
	logic [NW-1:0]  rem_sh;
	logic [NW-1:0]  mag;
	logic [NW-1:0]  prod_abs;
	logic [16:0]    scale;

	assign scale    = {pixels, 4'b0};
	assign prod_abs = NW'(num[63] ? 64'(-num) : 64'(num)) * NW'(scale);
	assign rem_sh   = {rem_q[NW-2:0], dvd_q[NW-1]};
	assign trial    = {1'b0, rem_sh} - {19'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q    <= '0;
			dvd_q    <= prod_abs;
			den_q    <= den;
			quo_q    <= '0;
			neg_q    <= num[63];
			zs_q     <= (pixels == '0);
		end else if (busy_q) begin
			dvd_q <= {dvd_q[NW-2:0], 1'b0};
			if (!trial[NW]) begin
				rem_q <= trial[NW-1:0];
				quo_q <= {quo_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[NW-2:0], 1'b0};
			end
		end
	end

	// final sign and saturation
	always_comb begin
		logic [NW:0] m;
		m   = {1'b0, quo_q} + {{NW{1'b0}}, (neg_q && rem_q != '0)};
		mag = m[NW-1:0];
		if (zs_q) begin
			pix = '0;
		end else if (!neg_q) begin
			pix = (mag > NW'(131071)) ? ssnpp_pkg::PIX_SAT_HI : 32'(mag);
		end else begin
			pix = (mag > NW'(65536)) ? ssnpp_pkg::PIX_SAT_LO : -32'(mag);
		end
	end

endmodule

### design/ssnpp_back.sv
// back end: matrix store, projection, pixel mapping and nearest compare
// depends on ssnpp_pkg and ssnpp_pixdiv

module ssnpp_back #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	output logic                  q_take,
	input  ssnpp_pkg::qitem_t     q_item,
	input  ssnpp_pkg::view_cfg_t  vcfg,
	input  logic                  restart,
	input  logic [31:0]           radius_sq,
	output logic                  res_valid,
	input  logic                  res_ready,
	output logic                  res_found,
	output logic [15:0]           res_id
);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_MUL  = 7'b0000010,
		ST_SUM  = 7'b0000100,
		ST_DIVS = 7'b0001000,
		ST_DIVW = 7'b0010000,
		ST_DIST = 7'b0100000,
		ST_OUT  = 7'b1000000
	} st_t;

	st_t                 st_q;
	logic [31:0]         mat_q [16];
	ssnpp_pkg::qitem_t   it_q;
	logic [1:0]          row_q;
	logic signed [63:0]  p0_q, p1_q, p2_q;
	logic signed [63:0]  clip_q [3];
	logic signed [63:0]  acc;
	logic [31:0]         best_q;
	logic [15:0]         bid_q;
	logic                have_q;
	logic signed [31:0]  sx_q, sy_q;
	logic                ax_q;
	logic                dv_start, dv_done;
	logic signed [63:0]  dv_num;
	logic [12:0]         dv_pix;
	logic signed [31:0]  dv_pix_out;
	logic signed [32:0]  dx, dy;
	logic [65:0]         dsq;

	assign q_take = (st_q == ST_IDLE) && q_valid;

	// matrix store, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 16; k++) mat_q[k] <= '0;
		end else if (q_take && !q_item.is_obj) begin
			mat_q[{q_item.row, 2'd0}] <= q_item.a;
			mat_q[{q_item.row, 2'd1}] <= q_item.b;
			mat_q[{q_item.row, 2'd2}] <= q_item.c;
			mat_q[{q_item.row, 2'd3}] <= q_item.d;
		end
	end

	// one matrix row, three products a cycle
	always_ff @(posedge clk) begin
		if (q_take) it_q <= q_item;
		if (st_q == ST_MUL) begin
			p0_q <= $signed(mat_q[{row_q, 2'd0}]) * $signed(it_q.a);
			p1_q <= $signed(mat_q[{row_q, 2'd1}]) * $signed(it_q.b);
			p2_q <= $signed(mat_q[{row_q, 2'd2}]) * $signed(it_q.c);
		end
		if (st_q == ST_SUM) clip_q[row_q == 2'd3 ? 2'd2 : row_q] <= acc;
		if (dv_done) begin
			if (!ax_q) sx_q <= dv_pix_out;
			else       sy_q <= dv_pix_out;
		end
	end

	assign acc = ssnpp_pkg::fshift(p0_q, FRAC_BITS) + ssnpp_pkg::fshift(p1_q, FRAC_BITS)
		+ ssnpp_pkg::fshift(p2_q, FRAC_BITS) + 64'($signed(mat_q[{row_q, 2'd3}]));

	// clip_q[2] holds w, [0] x, [1] y
	assign dv_start = (st_q == ST_DIVS);
	assign dv_num   = ax_q ? (clip_q[2] - clip_q[1]) : (clip_q[0] + clip_q[2]);
	assign dv_pix   = ax_q ? vcfg.height : vcfg.width;

	ssnpp_pixdiv u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dv_start),
		.num    (dv_num),
		.den    ({clip_q[2][62:0], 1'b0}),
		.pixels (dv_pix),
		.done   (dv_done),
		.pix    (dv_pix_out)
	);

	assign dx  = 33'(sx_q) - 33'($signed({1'b0, vcfg.cur_x}));
	assign dy  = 33'(sy_q) - 33'($signed({1'b0, vcfg.cur_y}));
	assign dsq = 66'(dx * dx) + 66'(dy * dy);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			row_q     <= 2'd3;
			ax_q      <= 1'b0;
			best_q    <= 32'd230400;
			bid_q     <= '0;
			have_q    <= 1'b0;
			res_valid <= 1'b0;
			res_found <= 1'b0;
			res_id    <= '0;
		end else begin
			if (res_valid && res_ready) res_valid <= 1'b0;
			if (restart) begin
				best_q <= radius_sq;
				bid_q  <= '0;
				have_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (q_take && q_item.is_obj) begin
						st_q  <= ST_MUL;
						row_q <= 2'd3;
					end
				end
				ST_MUL: st_q <= ST_SUM;
				ST_SUM: begin
					if (row_q == 2'd3) begin
						if (acc <= 0) begin
							st_q <= ST_OUT;
						end else begin
							row_q <= 2'd0;
							st_q  <= ST_MUL;
						end
					end else if (row_q == 2'd0) begin
						row_q <= 2'd1;
						st_q  <= ST_MUL;
					end else begin
						ax_q <= 1'b0;
						st_q <= ST_DIVS;
					end
				end
				ST_DIVS: st_q <= ST_DIVW;
				ST_DIVW: begin
					if (dv_done) begin
						if (!ax_q) begin
							ax_q <= 1'b1;
							st_q <= ST_DIVS;
						end else begin
							st_q <= ST_DIST;
						end
					end
				end
				ST_DIST: begin
					// both pixels are registered by now; saturated never picks
					st_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!it_q.last) begin
						st_q <= ST_IDLE;
					end else if (!res_valid) begin
						res_valid <= 1'b1;
						res_found <= have_q;
						res_id    <= have_q ? bid_q : '0;
						best_q    <= radius_sq;
						bid_q     <= '0;
						have_q    <= 1'b0;
						st_q      <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
			if (st_q == ST_DIST && dsq < 66'(best_q)) begin
				best_q <= dsq[31:0];
				bid_q  <= it_q.id;
				have_q <= 1'b1;
			end
		end
	end

endmodule

### sim/pick_checker.sv
// checker for the screen-space nearest point pick core: predicts each pick and compares
// depends on ssnpp_pkg; watches the stream and config channels of the block

module pick_checker #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [247:0] s_axis_tdata,
	input  logic         s_axis_tuser,
	input  logic         s_axis_tlast,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [15:0]  m_axis_tdata,
	input  logic         m_axis_tuser,
	input  logic         cfg_valid,
	input  logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [15:0]  cfg_data,
	output int           fails,
	output int           pending
);

	typedef struct {
		logic        found;
		logic [15:0] id;
	} pick_res_t;

	pick_res_t   picks_due[$];
	logic [31:0] mat [16];
	logic [12:0] vw, vh;
	logic [15:0] cur_x, cur_y, radius;
	logic [31:0] best_sq;
	logic [15:0] best_id;
	logic        have_best;

	initial begin
		fails = 0;
		pending = 0;
	end

	task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
		$display("mismatch: %s got %h want %h", what, got, want);
		fails++;
	endtask

	function automatic longint clip_coord(input int r, input longint x, input longint y,
			input longint z);
		longint acc;
		acc = (longint'($signed(mat[r*4])) * x) >>> FRAC_BITS;
		acc += (longint'($signed(mat[r*4+1])) * y) >>> FRAC_BITS;
		acc += (longint'($signed(mat[r*4+2])) * z) >>> FRAC_BITS;
		acc += longint'($signed(mat[r*4+3]));
		return acc;
	endfunction

	// floor(n * px * 16 / 2w), saturated, in wide arithmetic
	function automatic longint to_pix(input longint n, input longint w, input logic [12:0] px);
		logic signed [127:0] num, den, s, q;
		s = {111'b0, px, 4'b0};
		num = n;
		num = num * s;
		den = w;
		den = den * 2;
		if (num >= 0)
			q = num / den;
		else
			q = -((-num + den - 1) / den);
		if (q > 131071)
			return 131071;
		if (q < -65536)
			return -65536;
		return longint'(q);
	endfunction

	task automatic restart();
		best_sq = {16'b0, radius} * {16'b0, radius};
		best_id = '0;
		have_best = 1'b0;
	endtask

	task automatic take_item();
		longint x, y, z, w, sx, sy, dx, dy, dsq;
		pick_res_t r;
		if (s_axis_tuser == 1'(ssnpp_pkg::MODE_ROW)) begin
			for (int k = 0; k < 4; k++)
				mat[s_axis_tdata[1:0]*4 + k] = s_axis_tdata[2+32*k +: 32];
		end else begin
			x = longint'($signed(s_axis_tdata[161:130]));
			y = longint'($signed(s_axis_tdata[193:162]));
			z = longint'($signed(s_axis_tdata[225:194]));
			w = clip_coord(3, x, y, z);
			if (w > 0) begin
				sx = to_pix(clip_coord(0, x, y, z) + w, w, vw);
				sy = to_pix(w - clip_coord(1, x, y, z), w, vh);
				dx = sx - longint'(cur_x);
				dy = sy - longint'(cur_y);
				dsq = dx * dx + dy * dy;
				if (dsq < longint'({32'b0, best_sq})) begin
					best_sq = dsq[31:0];
					best_id = s_axis_tdata[241:226];
					have_best = 1'b1;
				end
			end
			if (s_axis_tlast) begin
				r.found = have_best;
				r.id = have_best ? best_id : 16'd0;
				picks_due.insert(picks_due.size(), r);
				restart();
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (mat[k])
				mat[k] = '0;
			vw = 13'd1024;
			vh = 13'd1024;
			cur_x = '0;
			cur_y = '0;
			radius = 16'd480;
			restart();
			picks_due.delete();
		end else begin
			// compare the result transaction first, it can only belong to an older pick
			if (m_axis_tvalid && m_axis_tready) begin
				if (picks_due.size() == 0) begin
					report("unexpected result", m_axis_tdata, 16'hxxxx);
				end else begin
					if (m_axis_tuser !== picks_due[0].found)
						report("found", 16'(m_axis_tuser), 16'(picks_due[0].found));
					if (m_axis_tdata !== picks_due[0].id)
						report("picked_id", m_axis_tdata, picks_due[0].id);
					void'(picks_due.pop_front());
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (ssnpp_pkg::reg_idx_t'(cfg_index))
					ssnpp_pkg::REG_WIDTH:  vw = cfg_data[12:0];
					ssnpp_pkg::REG_HEIGHT: vh = cfg_data[12:0];
					ssnpp_pkg::REG_CUR_X:  cur_x = cfg_data;
					ssnpp_pkg::REG_CUR_Y:  cur_y = cfg_data;
					ssnpp_pkg::REG_RADIUS: begin
						radius = cfg_data;
						restart();
					end
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				take_item();
		end
		pending = picks_due.size();
	end

endmodule

### sim/testbench.sv
// top of the pick core testbench: clock, reset, stimulus and verdict
// depends on ssnpp_pkg, screen_space_nearest_point_pick_core and pick_checker

module testbench;

	localparam int unsigned LIMIT = 4000000;
	// an object can still be in flight when the last result is out
	localparam int unsigned DRAIN = 400;
	localparam int unsigned ITEMS = 1950;
	localparam logic [31:0] ONE = 32'd65536;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [247:0] s_axis_tdata = '0;
	logic         s_axis_tuser = 1'b0;
	logic         s_axis_tlast = 1'b0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [15:0]  m_axis_tdata;
	logic         m_axis_tuser;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [2:0]   cfg_index = '0;
	logic [15:0]  cfg_data = '0;
	int           fails, pending;

	int unsigned  cycles = 0;
	int unsigned  burst_left = 0;
	int unsigned  items_sent = 0;
	int unsigned  rx_left = 0, rx_mode = 0;
	// viewport and cursor as last written, used to aim objects at the cursor
	int unsigned  cur_w = 1024, cur_h = 1024, cx_q = 0, cy_q = 0, rad = 480;

	screen_space_nearest_point_pick_core dut (.*);

	pick_checker chk (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// receiver stalls in phases: always ready, light, heavy, long stretches
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_left = $urandom_range(20, 300);
		end
		rx_left--;
		case (rx_mode)
			0: m_axis_tready = 1'b1;
			1: m_axis_tready = ($urandom_range(0, 3) != 0);
			2: m_axis_tready = ($urandom_range(0, 7) == 0);
			default: m_axis_tready = ((rx_left % 50) < 5);
		endcase
	end

	// one input transaction, with bursts and random gaps
	task automatic send(input logic md, input logic [1:0] row, input logic [31:0] a,
			input logic [31:0] b, input logic [31:0] c, input logic [31:0] d,
			input logic [31:0] px, input logic [31:0] py, input logic [31:0] pz,
			input logic [15:0] id, input logic lst);
		if (burst_left == 0) begin
			repeat ($urandom_range(0, 9) == 0 ? $urandom_range(10, 40) : $urandom_range(0, 5))
				@(negedge clk);
			burst_left = $urandom_range(1, 40);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tuser = md;
		s_axis_tlast = lst;
		s_axis_tdata = {6'b0, id, pz, py, px, d, c, b, a, row};
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		burst_left--;
		items_sent++;
	endtask

	task automatic row_load(input logic [1:0] row, input logic [31:0] a, input logic [31:0] b,
			input logic [31:0] c, input logic [31:0] d);
		send(1'(ssnpp_pkg::MODE_ROW), row, a, b, c, d, $urandom, $urandom, $urandom,
			16'($urandom), 1'($urandom));
	endtask

	task automatic obj(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z,
			input logic [15:0] id, input logic lst);
		send(1'(ssnpp_pkg::MODE_OBJ), 2'($urandom), $urandom, $urandom, $urandom, $urandom,
			x, y, z, id, lst);
	endtask

	// block is idle: nothing owed and nothing left in the pipeline
	task automatic settle();
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN) @(negedge clk);
	endtask

	task automatic cfg_write(input ssnpp_pkg::reg_idx_t idx, input logic [15:0] val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
		case (idx)
			ssnpp_pkg::REG_WIDTH:  cur_w = val[12:0];
			ssnpp_pkg::REG_HEIGHT: cur_h = val[12:0];
			ssnpp_pkg::REG_CUR_X:  cx_q = val;
			ssnpp_pkg::REG_CUR_Y:  cy_q = val;
			ssnpp_pkg::REG_RADIUS: rad = val;
			default: ;
		endcase
	endtask

	// object aimed near the cursor for the matrix with w = z
	task automatic near_obj(input logic lst);
		longint z, tx, ty, x, y;
		int jr;
		z = $urandom_range(65536, 1 << 22);
		jr = (rad > 200) ? 200 : rad + 2;
		tx = longint'(cx_q) + $urandom_range(0, 2 * jr) - jr;
		ty = longint'(cy_q) + $urandom_range(0, 2 * jr) - jr;
		x = (tx * 2 * z) / (cur_w * 16) - z;
		y = z - (ty * 2 * z) / (cur_h * 16);
		obj(x[31:0], y[31:0], z[31:0], 16'($urandom), lst);
	endtask

	task automatic random_phase();
		int unsigned n, goal;
		logic noise_mat;
		settle();
		case ($urandom_range(0, 2))
			0: cfg_write(ssnpp_pkg::REG_WIDTH, 16'd1);
			1: cfg_write(ssnpp_pkg::REG_WIDTH, 16'd4096);
			default: cfg_write(ssnpp_pkg::REG_WIDTH, 16'($urandom_range(1, 4096)));
		endcase
		case ($urandom_range(0, 2))
			0: cfg_write(ssnpp_pkg::REG_HEIGHT, 16'd1);
			1: cfg_write(ssnpp_pkg::REG_HEIGHT, 16'd4096);
			default: cfg_write(ssnpp_pkg::REG_HEIGHT, 16'($urandom_range(1, 4096)));
		endcase
		if ($urandom_range(0, 4) == 0) begin
			cfg_write(ssnpp_pkg::REG_CUR_X, 16'($urandom));
			cfg_write(ssnpp_pkg::REG_CUR_Y, 16'($urandom));
		end else begin
			cfg_write(ssnpp_pkg::REG_CUR_X, 16'($urandom_range(0, cur_w * 16 - 1)));
			cfg_write(ssnpp_pkg::REG_CUR_Y, 16'($urandom_range(0, cur_h * 16 - 1)));
		end
		case ($urandom_range(0, 4))
			0: cfg_write(ssnpp_pkg::REG_RADIUS, 16'd0);
			1: cfg_write(ssnpp_pkg::REG_RADIUS, 16'hffff);
			default: cfg_write(ssnpp_pkg::REG_RADIUS, 16'($urandom_range(1, 2000)));
		endcase
		noise_mat = ($urandom_range(0, 4) == 0);
		if (noise_mat) begin
			for (int r = 0; r < 4; r++)
				row_load(2'(r), $urandom, $urandom, $urandom, $urandom);
		end else begin
			row_load(2'd2, $urandom, $urandom, $urandom, $urandom);
			row_load(2'd3, 32'd0, 32'd0, ONE, 32'd0);
			row_load(2'd1, 32'd0, ONE, 32'd0, 32'd0);
			row_load(2'd0, ONE, 32'd0, 32'd0, 32'd0);
		end
		goal = items_sent + $urandom_range(100, 200);
		if (goal > ITEMS)
			goal = ITEMS;
		while (items_sent < goal) begin
			n = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 30) : $urandom_range(1, 8);
			for (int k = 1; k <= n; k++) begin
				case ($urandom_range(0, 19))
					0, 1: obj($urandom, $urandom, $urandom, 16'($urandom), k == n);
					2, 3: obj($urandom, $urandom, -$urandom_range(0, 1 << 22),
							16'($urandom), k == n);
					4: begin
						// matrix disturbed in the middle of a pick
						row_load(2'($urandom), $urandom, $urandom, $urandom, $urandom);
						near_obj(k == n);
					end
					default: near_obj(k == n);
				endcase
			end
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: center of a 1024 screen, fixed w of one
		cfg_write(ssnpp_pkg::REG_WIDTH, 16'd1024);
		cfg_write(ssnpp_pkg::REG_HEIGHT, 16'd1024);
		cfg_write(ssnpp_pkg::REG_CUR_X, 16'd8192);
		cfg_write(ssnpp_pkg::REG_CUR_Y, 16'd8192);
		cfg_write(ssnpp_pkg::REG_RADIUS, 16'd480);
		row_load(2'd0, ONE, 32'd0, 32'd0, 32'd0);
		row_load(2'd1, 32'd0, ONE, 32'd0, 32'd0);
		// row with last
		send(1'(ssnpp_pkg::MODE_ROW), 2'd2, 32'd0, 32'd0, ONE, 32'd0, 32'd0, 32'd0, 32'd0,
			16'd0, 1'b1);
		row_load(2'd3, 32'd0, 32'd0, 32'd0, ONE);
		// equal distance, the earlier object stays
		obj(32'd0, 32'd0, 32'd0, 16'hffff, 1'b0);
		obj(32'd0, 32'd0, 32'd0, 16'd1, 1'b1);
		// saturated pixels
		obj(32'h7fffffff, 32'h80000000, 32'h7fffffff, 16'd0, 1'b1);
		// w not positive
		row_load(2'd3, 32'd0, 32'd0, 32'd0, -ONE);
		obj(32'd0, 32'd0, 32'd0, 16'd2, 1'b1);
		row_load(2'd3, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000);
		obj(32'h80000000, 32'h7fffffff, 32'h80000000, 16'd3, 1'b1);
		row_load(2'd3, 32'd0, 32'd0, 32'd0, ONE);
		// nearest of three
		obj(32'd40, 32'd0, 32'd0, 16'd5, 1'b0);
		obj(32'd8, 32'd0, 32'd0, 16'd6, 1'b0);
		obj(32'h00800000, 32'd0, 32'd0, 16'd7, 1'b1);
		settle();
		// writes to unused indexes, masked and zero viewport sizes
		cfg_write(ssnpp_pkg::reg_idx_t'(3'd5), 16'hffff);
		cfg_write(ssnpp_pkg::reg_idx_t'(3'd7), 16'hffff);
		cfg_write(ssnpp_pkg::REG_WIDTH, 16'd0);
		cfg_write(ssnpp_pkg::REG_HEIGHT, 16'hffff);
		cfg_write(ssnpp_pkg::REG_CUR_X, 16'd0);
		obj(32'd0, 32'd0, 32'd0, 16'd8, 1'b1);
		settle();
		cfg_write(ssnpp_pkg::REG_RADIUS, 16'd0);
		obj(32'd0, 32'd0, 32'd0, 16'd9, 1'b1);
		settle();
		cfg_write(ssnpp_pkg::REG_RADIUS, 16'hffff);
		obj(32'h0000ffff, 32'hffff0000, 32'd0, 16'd10, 1'b1);

		while (items_sent < ITEMS)
			random_phase();

		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN) @(negedge clk);
		if (fails == 0 && pending == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
